/* rtl/dnd_pkg.sv */
package dnd_pkg;

	localparam int UNIT_W = 6;
	localparam int CHAR_W = 8;
	localparam int HASH_W = 32;
	localparam int UNIT_CODES = 1 << UNIT_W;

	localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

	localparam int SLOTS_DEF = 128;
	localparam int NAME_LEN_DEF = 32;
	localparam int MAX_UNITS_DEF = 64;

	// hash bits folded into the slot remainder per cycle
	localparam int MOD_STEP = 4;
	localparam int MOD_ROUNDS = HASH_W / MOD_STEP;

	typedef enum logic {
		KIND_CHAR = 1'b0,
		KIND_CLEAR = 1'b1
	} kind_t;

	typedef logic [UNIT_W-1:0] unit_t;
	typedef logic [CHAR_W-1:0] char_t;

	// unit code reduced modulo m, built at elaboration by counting
	function automatic logic [UNIT_CODES-1:0][UNIT_W-1:0] unit_mod_table(input int m);
		logic [UNIT_CODES-1:0][UNIT_W-1:0] t;
		int r;
		r = 0;
		for (int i = 0; i < UNIT_CODES; i++) begin
			t[i] = UNIT_W'(r);
			r = (r + 1 == m) ? 0 : r + 1;
		end
		return t;
	endfunction

endpackage

/* rtl/dnd_if.sv */
interface dnd_in_if;
	import dnd_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	unit_t unit_index;
	char_t char_byte;
	logic  last_char;

	modport source (output valid, kind, unit_index, char_byte, last_char, input ready);
	modport sink (input valid, kind, unit_index, char_byte, last_char, output ready);
endinterface

interface dnd_out_if;
	import dnd_pkg::*;

	logic  valid;
	logic  ready;
	logic  duplicate;
	logic  table_full;
	unit_t earlier_unit;

	modport source (output valid, duplicate, table_full, earlier_unit, input ready);
	modport sink (input valid, duplicate, table_full, earlier_unit, output ready);
endinterface

/* rtl/duplicate_name_detector_unit.sv */
// Character beats are taken one per cycle while the block is idle. A last beat starts the finish:
// zero fill of the name entry and the slot remainder run side by side until both are done, then
// each probed slot is read and checked, and an occupied slot's name bytes are read and compared
// in turn; the output register is loaded once it is free, after which the next beat can be taken.
// A clear beat and reset both start a sweep over every slot of the slot memory during
// which no beat is taken. Reset is asynchronous and clears all control state.
module duplicate_name_detector_unit #(
	parameter int SLOTS = dnd_pkg::SLOTS_DEF,
	parameter int NAME_LEN = dnd_pkg::NAME_LEN_DEF,
	parameter int MAX_UNITS = dnd_pkg::MAX_UNITS_DEF
) (
	input logic clk,
	input logic arst_n,
	dnd_in_if.sink items,
	dnd_out_if.source results
);
	import dnd_pkg::*;

	localparam int UNITS = (MAX_UNITS < UNIT_CODES) ? MAX_UNITS : UNIT_CODES;
	localparam int UW = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int NW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
	localparam int CW = $clog2(NAME_LEN + 1);
	localparam int SW = $clog2(SLOTS);
	localparam int AW = UW + NW;
	localparam int STORE_DEPTH = UNITS << NW;
	localparam int MRW = $clog2(MOD_ROUNDS + 1);

	localparam logic [UNIT_CODES-1:0][UNIT_W-1:0] UNIT_MOD = unit_mod_table(MAX_UNITS);
	localparam logic [CW-1:0] LEN_C = CW'(NAME_LEN);
	localparam logic [NW-1:0] NAME_LAST = NW'(NAME_LEN - 1);
	localparam logic [SW:0] SLOTS_C = (SW + 1)'(SLOTS);
	localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
	localparam logic [MRW-1:0] MOD_DONE = MRW'(MOD_ROUNDS);

	typedef enum logic [7:0] {
		ST_CLEAR    = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_FINISH   = 8'b0000_0100,
		ST_SLOT_RD  = 8'b0000_1000,
		ST_SLOT_CHK = 8'b0001_0000,
		ST_CMP_RD   = 8'b0010_0000,
		ST_CMP_CHK  = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	// memories
	char_t        name_mem [STORE_DEPTH];
	logic [UW:0]  slot_mem [SLOTS];

	state_t            state_q;
	logic [HASH_W-1:0] hash_q;
	logic [CW-1:0]     count_q;
	logic              ended_q;
	logic [UW-1:0]     unit_q;
	logic [CW-1:0]     fill_q;
	logic [MRW-1:0]    mod_cnt_q;
	logic [SW-1:0]     k_q;
	logic [SW-1:0]     p_q;
	logic [UW-1:0]     owner_q;
	logic [NW-1:0]     n_q;
	logic              res_dup_q;
	logic              res_full_q;
	logic [UW-1:0]     res_earlier_q;
	logic              out_valid_q;
	logic              out_dup_q;
	logic              out_full_q;
	unit_t             out_earlier_q;

	char_t             nm_a_q;
	char_t             nm_b_q;
	logic [UW:0]       slot_rd_q;

	logic              in_acc;
	logic [UW-1:0]     in_unit;
	logic              take_char;
	logic [HASH_W-1:0] hash_next;
	logic              nm_we;
	logic [AW-1:0]     nm_waddr;
	char_t             nm_wdata;
	logic              sl_we;
	logic [UW:0]       sl_wdata;
	logic [SW:0]       mod_t;
	logic [SW-1:0]     mod_r;
	logic [SW-1:0]     k_next;
	logic              out_load;

	assign items.ready = (state_q == ST_IDLE);
	assign in_acc = items.valid && items.ready;
	assign in_unit = UNIT_MOD[items.unit_index][UW-1:0];
	assign take_char = !ended_q && (items.char_byte != '0) && (count_q < LEN_C);
	assign hash_next = HASH_W'((hash_q ^ HASH_W'(items.char_byte)) * FNV_PRIME);
	assign k_next = (k_q == SLOT_LAST) ? '0 : k_q + SW'(1);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	assign results.valid = out_valid_q;
	assign results.duplicate = out_dup_q;
	assign results.table_full = out_full_q;
	assign results.earlier_unit = out_earlier_q;

	// name store write port: incoming characters, then the zero fill
	always_comb begin
		nm_we = 1'b0;
		nm_waddr = {in_unit, count_q[NW-1:0]};
		nm_wdata = items.char_byte;
		if (state_q == ST_IDLE) begin
			nm_we = in_acc && (items.kind == KIND_CHAR) && take_char;
		end else if (state_q == ST_FINISH) begin
			nm_we = (fill_q != LEN_C);
			nm_waddr = {unit_q, fill_q[NW-1:0]};
			nm_wdata = '0;
		end
	end

	// slot write port: clearing sweep or claiming a free slot
	always_comb begin
		sl_we = 1'b0;
		sl_wdata = '0;
		if (state_q == ST_CLEAR) begin
			sl_we = 1'b1;
		end else if (state_q == ST_SLOT_CHK && !slot_rd_q[UW]) begin
			sl_we = 1'b1;
			sl_wdata = {1'b1, unit_q};
		end
	end

	// hash modulo SLOTS, MOD_STEP bits per round, remainder kept in k_q
	always_comb begin
		mod_r = k_q;
		mod_t = '0;
		for (int i = 0; i < MOD_STEP; i++) begin
			mod_t = {mod_r, hash_q[HASH_W-1-i]};
			if (mod_t >= SLOTS_C) begin
				mod_t = mod_t - SLOTS_C;
			end
			mod_r = mod_t[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (nm_we) begin
			name_mem[nm_waddr] <= nm_wdata;
		end
		if (state_q == ST_CMP_RD) begin
			nm_a_q <= name_mem[{owner_q, n_q}];
			nm_b_q <= name_mem[{unit_q, n_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (sl_we) begin
			slot_mem[k_q] <= sl_wdata;
		end
		if (state_q == ST_SLOT_RD) begin
			slot_rd_q <= slot_mem[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			hash_q <= FNV_BASIS;
			count_q <= '0;
			ended_q <= 1'b0;
			unit_q <= '0;
			fill_q <= '0;
			mod_cnt_q <= '0;
			k_q <= '0;
			p_q <= '0;
			owner_q <= '0;
			n_q <= '0;
			res_dup_q <= 1'b0;
			res_full_q <= 1'b0;
			res_earlier_q <= '0;
			out_valid_q <= 1'b0;
			out_dup_q <= 1'b0;
			out_full_q <= 1'b0;
			out_earlier_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (k_q == SLOT_LAST) begin
						k_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + SW'(1);
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (items.kind == KIND_CLEAR) begin
							hash_q <= FNV_BASIS;
							count_q <= '0;
							ended_q <= 1'b0;
							k_q <= '0;
							state_q <= ST_CLEAR;
						end else begin
							if (!ended_q && items.char_byte == '0) begin
								ended_q <= 1'b1;
							end
							if (take_char) begin
								hash_q <= hash_next;
								count_q <= count_q + CW'(1);
							end
							if (items.last_char) begin
								unit_q <= in_unit;
								fill_q <= take_char ? count_q + CW'(1) : count_q;
								k_q <= '0;
								mod_cnt_q <= '0;
								state_q <= ST_FINISH;
							end
						end
					end
				end
				ST_FINISH: begin
					if (fill_q != LEN_C) begin
						fill_q <= fill_q + CW'(1);
					end
					if (mod_cnt_q != MOD_DONE) begin
						k_q <= mod_r;
						hash_q <= hash_q << MOD_STEP;
						mod_cnt_q <= mod_cnt_q + MRW'(1);
					end
					if (fill_q == LEN_C && mod_cnt_q == MOD_DONE) begin
						p_q <= '0;
						state_q <= ST_SLOT_RD;
					end
				end
				ST_SLOT_RD: begin
					state_q <= ST_SLOT_CHK;
				end
				ST_SLOT_CHK: begin
					if (!slot_rd_q[UW]) begin
						res_dup_q <= 1'b0;
						res_full_q <= 1'b0;
						res_earlier_q <= '0;
						state_q <= ST_DONE;
					end else begin
						owner_q <= slot_rd_q[UW-1:0];
						n_q <= '0;
						state_q <= ST_CMP_RD;
					end
				end
				ST_CMP_RD: begin
					state_q <= ST_CMP_CHK;
				end
				ST_CMP_CHK: begin
					if (nm_a_q != nm_b_q) begin
						if (p_q == SLOT_LAST) begin
							res_dup_q <= 1'b0;
							res_full_q <= 1'b1;
							res_earlier_q <= '0;
							state_q <= ST_DONE;
						end else begin
							p_q <= p_q + SW'(1);
							k_q <= k_next;
							state_q <= ST_SLOT_RD;
						end
					end else if (nm_a_q == '0 || n_q == NAME_LAST) begin
						res_dup_q <= 1'b1;
						res_full_q <= 1'b0;
						res_earlier_q <= owner_q;
						state_q <= ST_DONE;
					end else begin
						n_q <= n_q + NW'(1);
						state_q <= ST_CMP_RD;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						out_dup_q <= res_dup_q;
						out_full_q <= res_full_q;
						out_earlier_q <= UNIT_W'(res_earlier_q);
						hash_q <= FNV_BASIS;
						count_q <= '0;
						ended_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					k_q <= '0;
				end
			endcase
		end
	end

endmodule

/* test/duplicate_name_detector_unit_tb.sv */
module duplicate_name_detector_unit_tb;
	import dnd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = SLOTS_DEF;
	localparam int NAME_LEN = NAME_LEN_DEF;
	localparam int UNITS = MAX_UNITS_DEF;
	localparam int MAX_WORD = 48;
	localparam int POOL_DEPTH = 24;
	localparam int BEATS_PER_PHASE = 160;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	localparam int GAP_PCT [4] = '{0, 47, 0, 8};
	localparam int STALL_PCT [4] = '{0, 0, 47, 8};

	typedef struct packed {
		kind_t kind;
		unit_t unit;
		char_t ch;
		logic last_char;
	} name_beat_t;

	typedef struct packed {
		logic duplicate;
		logic table_full;
		unit_t earlier_unit;
	} verdict_t;

	typedef struct packed {
		name_beat_t beat;
		logic pinned;
		verdict_t want;
	} script_row_t;

	typedef logic [MAX_WORD*CHAR_W-1:0] word_t;

	localparam verdict_t FRESH = '{1'b0, 1'b0, 6'd0};
	localparam int SCRIPT_ROWS = 18;
	localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
		'{'{KIND_CHAR, 6'd5, 8'h41, 1'b0}, 1'b0, FRESH},
		'{'{KIND_CHAR, 6'd5, 8'h42, 1'b1}, 1'b1, FRESH},
		'{'{KIND_CHAR, 6'd9, 8'h41, 1'b0}, 1'b0, FRESH},
		'{'{KIND_CHAR, 6'd9, 8'h42, 1'b1}, 1'b1, '{1'b1, 1'b0, 6'd5}},
		'{'{KIND_CHAR, 6'd63, 8'hFF, 1'b1}, 1'b1, FRESH},
		'{'{KIND_CHAR, 6'd0, 8'h00, 1'b1}, 1'b1, FRESH},
		'{'{KIND_CHAR, 6'd1, 8'h00, 1'b0}, 1'b0, FRESH},
		'{'{KIND_CHAR, 6'd1, 8'h5A, 1'b0}, 1'b0, FRESH},
		'{'{KIND_CHAR, 6'd1, 8'h01, 1'b1}, 1'b1, '{1'b1, 1'b0, 6'd0}},
		'{'{KIND_CHAR, 6'd5, 8'h41, 1'b0}, 1'b0, FRESH},
		'{'{KIND_CHAR, 6'd5, 8'h42, 1'b1}, 1'b1, '{1'b1, 1'b0, 6'd5}},
		'{'{KIND_CHAR, 6'd9, 8'h41, 1'b0}, 1'b0, FRESH},
		'{'{KIND_CHAR, 6'd5, 8'h42, 1'b1}, 1'b0, FRESH},
		'{'{KIND_CHAR, 6'd7, 8'h51, 1'b0}, 1'b0, FRESH},
		'{'{KIND_CLEAR, 6'd63, 8'hFF, 1'b1}, 1'b0, FRESH},
		'{'{KIND_CHAR, 6'd7, 8'h51, 1'b1}, 1'b1, FRESH},
		'{'{KIND_CHAR, 6'd62, 8'h80, 1'b0}, 1'b0, FRESH},
		'{'{KIND_CHAR, 6'd62, 8'h7F, 1'b1}, 1'b0, FRESH}
	};

	logic clk;
	logic arst_n;

	dnd_in_if item_bus ();
	dnd_out_if result_bus ();

	duplicate_name_detector_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_bus),
		.results(result_bus)
	);

	// mirror of the slot table and name store
	logic [SLOTS-1:0] slot_taken;
	unit_t slot_holder [SLOTS];
	char_t unit_name [UNITS][NAME_LEN];
	logic [NAME_LEN-1:0] byte_set [UNITS];
	logic [HASH_W-1:0] run_hash;
	int run_len;
	logic run_done;

	verdict_t verdict_q [$];
	verdict_t oldest;
	word_t word_pool [$];
	int word_len [$];

	int gap_pct;
	int stall_pct;
	int fails;
	int beats_sent;
	int names_checked;
	int dups_seen;
	int fulls_seen;
	int clears_sent;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h, input char_t c);
		return (h ^ HASH_W'(c)) * FNV_PRIME;
	endfunction

	function automatic void restart_name();
		run_hash = FNV_BASIS;
		run_len = 0;
		run_done = 1'b0;
	endfunction

	function automatic logic names_match(input unit_t a, input unit_t b);
		for (int n = 0; n < NAME_LEN; n++) begin
			if (unit_name[a][n] != unit_name[b][n])
				return 1'b0;
			if (unit_name[a][n] == 8'd0)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	// returns 1 when the beat finishes a name, with its verdict in v
	function automatic logic dedup_step(input name_beat_t b, output verdict_t v);
		int probe_base;
		int k;
		v = FRESH;
		if (b.kind == KIND_CLEAR) begin
			slot_taken = '0;
			restart_name();
			return 1'b0;
		end
		if (!run_done) begin
			if (b.ch == 8'd0) begin
				run_done = 1'b1;
			end else if (run_len < NAME_LEN) begin
				unit_name[b.unit][run_len] = b.ch;
				byte_set[b.unit][run_len] = 1'b1;
				run_hash = fnv_fold(run_hash, b.ch);
				run_len++;
			end
		end
		if (!b.last_char)
			return 1'b0;
		for (int n = run_len; n < NAME_LEN; n++) begin
			unit_name[b.unit][n] = 8'd0;
			byte_set[b.unit][n] = 1'b1;
		end
		v.table_full = 1'b1;
		probe_base = int'(run_hash % SLOTS);
		for (int p = 0; p < SLOTS; p++) begin
			k = (probe_base + p) % SLOTS;
			if (!slot_taken[k]) begin
				slot_taken[k] = 1'b1;
				slot_holder[k] = b.unit;
				v.table_full = 1'b0;
				break;
			end
			if (names_match(slot_holder[k], b.unit)) begin
				v.duplicate = 1'b1;
				v.table_full = 1'b0;
				v.earlier_unit = slot_holder[k];
				break;
			end
		end
		restart_name();
		return 1'b1;
	endfunction

	task automatic send_beat(input name_beat_t b, input logic pinned, input verdict_t want);
		verdict_t v;
		logic done;
		while ($urandom_range(0, 99) < gap_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.kind <= b.kind;
		item_bus.unit_index <= b.unit;
		item_bus.char_byte <= b.ch;
		item_bus.last_char <= b.last_char;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		done = dedup_step(b, v);
		if (done)
			verdict_q.push_back(pinned ? want : v);
		beats_sent++;
	endtask

	task automatic send_clear();
		name_beat_t b;
		b.kind = KIND_CLEAR;
		b.unit = unit_t'($urandom_range(0, UNITS - 1));
		b.ch = char_t'($urandom_range(0, 255));
		b.last_char = 1'($urandom_range(0, 1));
		clears_sent++;
		send_beat(b, 1'b0, FRESH);
	endtask

	// hop: all but the final beat go to random units; finish: flag the final beat last
	task automatic send_word(input unit_t owner, input word_t w, input int len, input bit hop,
			input bit finish);
		name_beat_t b;
		for (int i = 0; i < len; i++) begin
			b.kind = KIND_CHAR;
			b.unit = (hop && i != len - 1) ? unit_t'($urandom_range(0, UNITS - 1)) : owner;
			b.ch = w[i*CHAR_W +: CHAR_W];
			b.last_char = finish && (i == len - 1);
			send_beat(b, 1'b0, FRESH);
		end
	endtask

	task automatic send_random_name();
		word_t w;
		int len;
		int roll;
		int shape;
		int idx;
		unit_t owner;
		unit_t cand;
		bit hop;
		w = '0;
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			send_clear();
			return;
		end
		owner = unit_t'($urandom_range(0, UNITS - 1));
		hop = 1'b0;
		if (word_pool.size() != 0 && $urandom_range(0, 99) < 40) begin
			idx = $urandom_range(0, word_pool.size() - 1);
			w = word_pool[idx];
			len = word_len[idx];
		end else begin
			shape = $urandom_range(0, 99);
			if (shape < 75)
				len = $urandom_range(1, 6);
			else if (shape < 85)
				len = $urandom_range(7, 20);
			else if (shape < 95)
				len = $urandom_range(NAME_LEN - 2, MAX_WORD);
			else
				len = NAME_LEN;
			for (int i = 0; i < len; i++)
				w[i*CHAR_W +: CHAR_W] = ($urandom_range(0, 99) < 4) ? 8'd0 :
					char_t'($urandom_range(1, 255));
			word_pool.push_back(w);
			word_len.push_back(len);
			if (word_pool.size() > POOL_DEPTH) begin
				void'(word_pool.pop_front());
				void'(word_len.pop_front());
			end
		end
		if (roll < 10) begin
			// name dropped part way by a clear
			send_word(owner, w, $urandom_range(1, len), 1'b0, 1'b0);
			send_clear();
			return;
		end
		if (roll < 18) begin
			// the finishing unit must hold a complete entry already
			for (int t = 0; t < 8; t++) begin
				cand = unit_t'($urandom_range(0, UNITS - 1));
				if (&byte_set[cand]) begin
					owner = cand;
					hop = 1'b1;
					break;
				end
			end
		end
		send_word(owner, w, len, hop, 1'b1);
	endtask

	// every slot taken by a name hashing straight onto it, then unit 63 finds no room
	task automatic fill_table();
		word_t w;
		logic [HASH_W-1:0] h;
		char_t c0;
		char_t c1;
		send_clear();
		for (int s = 0; s < SLOTS; s++) begin
			do begin
				c0 = char_t'($urandom_range(1, 255));
				c1 = char_t'($urandom_range(1, 255));
				h = fnv_fold(fnv_fold(FNV_BASIS, c0), c1);
			end while (h % SLOTS != s);
			w = '0;
			w[0 +: CHAR_W] = c0;
			w[CHAR_W +: CHAR_W] = c1;
			send_word(unit_t'(s % (UNITS - 1)), w, 2, 1'b0, 1'b1);
		end
		repeat (2) begin
			w = '0;
			for (int i = 0; i < 3; i++)
				w[i*CHAR_W +: CHAR_W] = char_t'($urandom_range(1, 255));
			send_word(unit_t'(UNITS - 1), w, 3, 1'b0, 1'b1);
		end
		send_clear();
	endtask

	always @(posedge clk) begin
		result_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (verdict_q.size() == 0) begin
				$error("result beat with nothing outstanding");
				fails++;
			end else begin
				oldest = verdict_q.pop_front();
				names_checked++;
				if (oldest.duplicate)
					dups_seen++;
				if (oldest.table_full)
					fulls_seen++;
				if (result_bus.duplicate !== oldest.duplicate) begin
					$error("duplicate: expected %0d, got %0d", oldest.duplicate,
						result_bus.duplicate);
					fails++;
				end
				if (result_bus.table_full !== oldest.table_full) begin
					$error("table_full: expected %0d, got %0d", oldest.table_full,
						result_bus.table_full);
					fails++;
				end
				if (result_bus.earlier_unit !== oldest.earlier_unit) begin
					$error("earlier_unit: expected %0d, got %0d", oldest.earlier_unit,
						result_bus.earlier_unit);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("duplicate_name_detector_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin
		int phase_start;
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.kind = KIND_CHAR;
		item_bus.unit_index = '0;
		item_bus.char_byte = '0;
		item_bus.last_char = 1'b0;
		result_bus.ready = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		fails = 0;
		beats_sent = 0;
		names_checked = 0;
		dups_seen = 0;
		fulls_seen = 0;
		clears_sent = 0;
		cycle_count = 0;
		slot_taken = '0;
		foreach (byte_set[u])
			byte_set[u] = '0;
		restart_name();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			gap_pct = GAP_PCT[ph];
			stall_pct = STALL_PCT[ph];
			if (ph == 0) begin
				for (int r = 0; r < SCRIPT_ROWS; r++) begin
					if (SCRIPT[r].beat.kind == KIND_CLEAR)
						clears_sent++;
					send_beat(SCRIPT[r].beat, SCRIPT[r].pinned, SCRIPT[r].want);
				end
			end
			if (ph == 2)
				fill_table();
			phase_start = beats_sent;
			while (beats_sent - phase_start < BEATS_PER_PHASE)
				send_random_name();
			// hold the sender back until the block has answered everything
			item_bus.valid <= 1'b0;
			do @(posedge clk); while (verdict_q.size() != 0);
		end

		repeat (SLOTS + 64) @(posedge clk);

		$display("duplicate_name_detector_unit_tb: %0d beats over 4 idle patterns, %0d clears",
			beats_sent, clears_sent);
		$display("duplicate_name_detector_unit_tb: %0d names checked, %0d duplicates, %0d full",
			names_checked, dups_seen, fulls_seen);
		if (fails == 0)
			$display("duplicate_name_detector_unit_tb: done, clean");
		else
			$display("duplicate_name_detector_unit_tb: done, errors");
		$finish;
	end

endmodule
